FILE: rtl/agkf_pkg.sv
// Package for the angle/gyro Kalman filter unit.
// Holds the Q16.16 helpers, register indexes and update steps; no dependencies.
package agkf_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_QANGLE = 2'd0;
  localparam logic [1:0] REG_QBIAS  = 2'd1;
  localparam logic [1:0] REG_RMEAS  = 2'd2;
  localparam logic [1:0] REG_DT     = 2'd3;

  // Update sequence, one step per product
  localparam logic [3:0] STEP_PRED_ANGLE = 4'd0;
  localparam logic [3:0] STEP_PRED_P00   = 4'd1;
  localparam logic [3:0] STEP_PRED_P01   = 4'd2;
  localparam logic [3:0] STEP_PRED_P11   = 4'd3;
  localparam logic [3:0] STEP_CORR_P00   = 4'd4;
  localparam logic [3:0] STEP_CORR_P01   = 4'd5;
  localparam logic [3:0] STEP_CORR_P10   = 4'd6;
  localparam logic [3:0] STEP_CORR_P11   = 4'd7;
  localparam logic [3:0] STEP_CORR_ANGLE = 4'd8;
  localparam logic [3:0] STEP_CORR_BIAS  = 4'd9;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    begin
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  // Magnitude of a signed 32-bit value (2^31 fits unsigned)
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    begin
      u = v;
      mag32 = v[31] ? (~u + 32'd1) : u;
    end
  endfunction

endpackage

FILE: rtl/angle_gyro_kalman_filter_unit.sv
// Top level of the angle/gyro two-state Kalman filter unit.
// Uses agkf_pkg for saturation, register indexes and update steps.
//
// One request at a time runs one filter update. A sequencer steps through
// the update with one shared radix-4 serial multiplier (a load state, the
// radix-4 digit states and a write-back state per product) and one
// bit-serial restoring divider (a 48-bit quotient, then a write-back
// state). An update takes 10 products and 2 quotients; the next request
// is taken only once the sequencer is back in idle after its output step.
// The result sits in an output register so the next update runs while it
// waits; the sequencer holds in its output step only if the previous
// result is still not taken.
module angle_gyro_kalman_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] angle_estimate, [63:32] corrected_rate
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_SET  = 7'b000_0010,
    S_MUL  = 7'b000_0100,
    S_MWB  = 7'b000_1000,
    S_DIV  = 7'b001_0000,
    S_DWB  = 7'b010_0000,
    S_OUT  = 7'b100_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [30:0] qa_r, qb_r, rm_r, dt_r;
  logic signed [31:0] ang_r, bias_r, p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] meas_r, rate_r, err_r, k0_r, k1_r;
  logic signed [31:0] t0_r, t1_r;
  logic [3:0]  step_r;

  // serial multiplier: a times b, 2 bits of b per cycle from the top
  logic signed [31:0] ma_r;
  logic [31:0]        mb_r;
  logic signed [65:0] macc_r;
  logic [3:0]         mcnt_r;
  logic signed [31:0] mop_a, mop_b;
  logic signed [33:0] ma_x1, ma_x2, mpp;
  logic signed [31:0] mres;

  // serial divider: |n|<<16 / |d|, 48-bit quotient
  logic [47:0] dq_r;
  logic [31:0] drem_r;
  logic [31:0] dden_r;
  logic        dneg_r;
  logic [5:0]  dcnt_r;
  logic        dsel_r;
  logic [33:0] dtry;
  logic signed [48:0] dq_mag;
  logic signed [31:0] dres, dquo;

  // shared terms
  logic signed [31:0] dt_s, rate_corr, var_c;

  // pre-computed predict differences
  logic signed [31:0] d0, d1;
  assign d0 = agkf_pkg::sat32(66'(agkf_pkg::sat32(66'($signed({1'b0, qa_r})) - 66'(p1_r)))
                              - 66'(p2_r));
  assign d1 = agkf_pkg::sat32(66'sd0 - 66'(p3_r));

  assign dt_s      = $signed({1'b0, dt_r});
  assign rate_corr = agkf_pkg::sat32(66'(rate_r) - 66'(bias_r));
  assign var_c     = agkf_pkg::sat32(66'($signed({1'b0, rm_r})) + 66'(p0_r));

  // operand selection per product step
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    case (step_r)
      agkf_pkg::STEP_PRED_ANGLE: begin mop_a = rate_corr; mop_b = dt_s; end
      agkf_pkg::STEP_PRED_P00:   begin mop_a = d0; mop_b = dt_s; end
      agkf_pkg::STEP_PRED_P01:   begin mop_a = d1; mop_b = dt_s; end
      agkf_pkg::STEP_PRED_P11:   begin mop_a = $signed({1'b0, qb_r}); mop_b = dt_s; end
      agkf_pkg::STEP_CORR_P00:   begin mop_a = k0_r; mop_b = t0_r; end
      agkf_pkg::STEP_CORR_P01:   begin mop_a = k0_r; mop_b = t1_r; end
      agkf_pkg::STEP_CORR_P10:   begin mop_a = k1_r; mop_b = t0_r; end
      agkf_pkg::STEP_CORR_P11:   begin mop_a = k1_r; mop_b = t1_r; end
      agkf_pkg::STEP_CORR_ANGLE: begin mop_a = k0_r; mop_b = err_r; end
      agkf_pkg::STEP_CORR_BIAS:  begin mop_a = k1_r; mop_b = err_r; end
      default: ;
    endcase
  end

  // partial product for one radix-4 digit; the top digit is signed
  assign ma_x1 = 34'(ma_r);
  assign ma_x2 = {ma_x1[32:0], 1'b0};
  assign mpp = (mb_r[30] ? ma_x1 : 34'sd0)
             + (mb_r[31] ? ((mcnt_r == 4'd0) ? -ma_x2 : ma_x2) : 34'sd0);

  // product >>> 16 (floor), saturated
  assign mres = agkf_pkg::sat32(macc_r >>> 16);

  // restoring divide step and signed, saturated quotient
  assign dtry   = {1'b0, drem_r, dq_r[47]} - {2'b00, dden_r};
  assign dq_mag = $signed({1'b0, dq_r});
  assign dres   = dneg_r ? agkf_pkg::sat32(66'sd0 - 66'(dq_mag))
                         : agkf_pkg::sat32(66'(dq_mag));
  // zero innovation variance gives a zero gain
  assign dquo   = (var_c == '0) ? '0 : dres;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SET;
      S_SET:  state_nxt = S_MUL;
      S_MUL:  if (mcnt_r == 4'd15) state_nxt = S_MWB;
      S_MWB:  begin
        if (step_r == agkf_pkg::STEP_PRED_P11) state_nxt = S_DIV;
        else if (step_r == agkf_pkg::STEP_CORR_BIAS) state_nxt = S_OUT;
        else state_nxt = S_SET;
      end
      S_DIV:  if (dcnt_r == 6'd47) state_nxt = S_DWB;
      S_DWB:  state_nxt = dsel_r ? S_SET : S_DIV;
      S_OUT:  if (!out_tvalid || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qa_r <= 31'd655; qb_r <= 31'd66; rm_r <= 31'd32768; dt_r <= 31'd19661;
      ang_r <= '0; bias_r <= '0;
      p0_r <= 32'sd65536; p1_r <= '0; p2_r <= '0; p3_r <= 32'sd65536;
      out_tvalid <= 1'b0;
      out_tdata <= '0;
      step_r <= '0;
      dsel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // config writes
      if (cfg_we) begin
        case (cfg_addr)
          agkf_pkg::REG_QANGLE: qa_r <= cfg_wdata;
          agkf_pkg::REG_QBIAS:  qb_r <= cfg_wdata;
          agkf_pkg::REG_RMEAS:  rm_r <= cfg_wdata;
          agkf_pkg::REG_DT:     dt_r <= cfg_wdata;
          default: ;
        endcase
      end
      // output register
      if (state_r == S_OUT && (!out_tvalid || out_tready)) begin
        out_tvalid <= 1'b1;
        out_tdata <= {rate_corr, ang_r};
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          // accept a request
          if (in_tvalid) begin
            meas_r <= in_tdata[31:0];
            rate_r <= in_tdata[63:32];
            step_r <= agkf_pkg::STEP_PRED_ANGLE;
          end
        end
        S_SET: begin
          ma_r <= mop_a; mb_r <= mop_b; macc_r <= '0; mcnt_r <= '0;
        end
        S_MUL: begin
          macc_r <= (macc_r <<< 2) + 66'(mpp);
          mb_r <= {mb_r[29:0], 2'b00};
          mcnt_r <= mcnt_r + 4'd1;
        end
        S_MWB: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            agkf_pkg::STEP_PRED_ANGLE: ang_r <= agkf_pkg::sat32(66'(ang_r) + 66'(mres));
            agkf_pkg::STEP_PRED_P00:   p0_r <= agkf_pkg::sat32(66'(p0_r) + 66'(mres));
            agkf_pkg::STEP_PRED_P01: begin
              p1_r <= agkf_pkg::sat32(66'(p1_r) + 66'(mres));
              p2_r <= agkf_pkg::sat32(66'(p2_r) + 66'(mres));
            end
            agkf_pkg::STEP_PRED_P11: begin
              p3_r <= agkf_pkg::sat32(66'(p3_r) + 66'(mres));
              err_r <= agkf_pkg::sat32(66'(meas_r) - 66'(ang_r));
              // divider setup for k0
              drem_r <= '0;
              dq_r <= {agkf_pkg::mag32(p0_r), 16'd0};
              dden_r <= agkf_pkg::mag32(var_c);
              dneg_r <= p0_r[31] ^ var_c[31];
              dcnt_r <= '0;
              dsel_r <= 1'b0;
            end
            agkf_pkg::STEP_CORR_P00:   p0_r <= agkf_pkg::sat32(66'(p0_r) - 66'(mres));
            agkf_pkg::STEP_CORR_P01:   p1_r <= agkf_pkg::sat32(66'(p1_r) - 66'(mres));
            agkf_pkg::STEP_CORR_P10:   p2_r <= agkf_pkg::sat32(66'(p2_r) - 66'(mres));
            agkf_pkg::STEP_CORR_P11:   p3_r <= agkf_pkg::sat32(66'(p3_r) - 66'(mres));
            agkf_pkg::STEP_CORR_ANGLE: ang_r <= agkf_pkg::sat32(66'(ang_r) + 66'(mres));
            agkf_pkg::STEP_CORR_BIAS:  bias_r <= agkf_pkg::sat32(66'(bias_r) + 66'(mres));
            default: ;
          endcase
        end
        S_DIV: begin
          // one restoring step
          if (!dtry[33]) begin
            drem_r <= dtry[31:0];
            dq_r <= {dq_r[46:0], 1'b1};
          end else begin
            drem_r <= {drem_r[30:0], dq_r[47]};
            dq_r <= {dq_r[46:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 6'd1;
        end
        S_DWB: begin
          if (!dsel_r) begin
            k0_r <= dquo;
            t0_r <= p0_r;
            t1_r <= p1_r;
            dsel_r <= 1'b1;
            // divider setup for k1
            drem_r <= '0;
            dq_r <= {agkf_pkg::mag32(p2_r), 16'd0};
            dden_r <= agkf_pkg::mag32(var_c);
            dneg_r <= p2_r[31] ^ var_c[31];
            dcnt_r <= '0;
          end else begin
            k1_r <= dquo;
            dsel_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench for angle_gyro_kalman_filter_unit: random and directed sensor samples
// are checked against an in-bench Kalman update predictor. Depends on agkf_pkg.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] accel;
  } sample_t;

  localparam logic signed [63:0] QMAX = 64'sd2147483647;
  localparam logic signed [63:0] QMIN = -64'sd2147483648;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [30:0] cfg_wdata = '0;

  angle_gyro_kalman_filter_unit DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Filter state mirrored from the block
  logic signed [63:0] q_angle, q_bias, r_meas, dt;
  logic signed [63:0] est_angle, est_bias;
  logic signed [63:0] cov [4];

  sample_t pending_samples[$];
  logic [63:0] expected_outputs[$];
  int errors = 0;
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat(p >>> 16);
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] n,
                                             input logic signed [63:0] d);
    logic signed [63:0] q;
    if (d == 0) return 0;
    q = (n * 64'sd65536) / d;
    return sat(q);
  endfunction

  // One filter update; returns {corrected_rate, angle}
  function automatic logic [63:0] kalman_update(input sample_t s);
    logic signed [63:0] meas, rate, d0, d1, err, pc0, pc1, v, k0, k1, t0, t1, cr;
    meas = s.accel;
    rate = s.rate;
    est_angle = sat(est_angle + qmul(sat(rate - est_bias), dt));
    d0 = sat(sat(q_angle - cov[1]) - cov[2]);
    d1 = sat(0 - cov[3]);
    cov[0] = sat(cov[0] + qmul(d0, dt));
    cov[1] = sat(cov[1] + qmul(d1, dt));
    cov[2] = sat(cov[2] + qmul(d1, dt));
    cov[3] = sat(cov[3] + qmul(q_bias, dt));
    err = sat(meas - est_angle);
    pc0 = cov[0];
    pc1 = cov[2];
    v = sat(r_meas + pc0);
    k0 = qdiv(pc0, v);
    k1 = qdiv(pc1, v);
    t0 = pc0;
    t1 = cov[1];
    cov[0] = sat(cov[0] - qmul(k0, t0));
    cov[1] = sat(cov[1] - qmul(k0, t1));
    cov[2] = sat(cov[2] - qmul(k1, t0));
    cov[3] = sat(cov[3] - qmul(k1, t1));
    est_angle = sat(est_angle + qmul(k0, err));
    est_bias = sat(est_bias + qmul(k1, err));
    cr = sat(rate - est_bias);
    return {cr[31:0], est_angle[31:0]};
  endfunction

  // Driver: present queued samples, predict on each accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_outputs.push_back(kalman_update(sample_t'(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && (no_idle || $urandom_range(99) >= 19)) begin
          in_tdata <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare results, random back-pressure, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_tdata);
        end else begin
          logic [63:0] exp_out;
          exp_out = expected_outputs.pop_front();
          if (exp_out[31:0] !== out_tdata[31:0]) begin
            errors++;
            $display("%0t: angle_estimate expected %h actual %h", $time,
                     exp_out[31:0], out_tdata[31:0]);
          end
          if (exp_out[63:32] !== out_tdata[63:32]) begin
            errors++;
            $display("%0t: corrected_rate expected %h actual %h", $time,
                     exp_out[63:32], out_tdata[63:32]);
          end
        end
      end
      out_tready <= no_idle || ($urandom_range(99) >= 19);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      agkf_pkg::REG_QANGLE: q_angle = val;
      agkf_pkg::REG_QBIAS:  q_bias = val;
      agkf_pkg::REG_RMEAS:  r_meas = val;
      agkf_pkg::REG_DT:     dt = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_outputs.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(2 * 655360)) - 655360);
    endcase
  endfunction

  task automatic push_random(input int n);
    repeat (n) pending_samples.push_back({rand_field(), rand_field()});
  endtask

  initial begin
    q_angle = 655; q_bias = 66; r_meas = 32768; dt = 19661;
    est_angle = 0; est_bias = 0;
    cov[0] = 65536; cov[1] = 0; cov[2] = 0; cov[3] = 65536;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes at reset settings
    pending_samples.push_back({32'sd0, 32'sd0});
    pending_samples.push_back({32'h7fffffff, 32'h7fffffff});
    pending_samples.push_back({32'h80000000, 32'h80000000});
    pending_samples.push_back({32'h80000000, 32'h7fffffff});
    pending_samples.push_back({32'hffffffff, 32'h00000001});
    pending_samples.push_back({32'h00010000, 32'hffff0000});
    pending_samples.push_back({32'h55555555, 32'haaaaaaaa});
    pending_samples.push_back({32'haaaaaaaa, 32'h55555555});
    drain();

    // Maximal noise and step drive saturation everywhere
    write_reg(agkf_pkg::REG_QANGLE, 31'h7fffffff);
    write_reg(agkf_pkg::REG_QBIAS, 31'h7fffffff);
    write_reg(agkf_pkg::REG_RMEAS, 31'h7fffffff);
    write_reg(agkf_pkg::REG_DT, 31'h7fffffff);
    push_random(8);
    drain();

    // Zero step and minimal noise; aim for a zero innovation variance
    write_reg(agkf_pkg::REG_QANGLE, 31'd0);
    write_reg(agkf_pkg::REG_QBIAS, 31'd0);
    write_reg(agkf_pkg::REG_DT, 31'd0);
    write_reg(agkf_pkg::REG_RMEAS, 31'd1);
    push_random(6);
    drain();

    // Random phases with varied settings; one phase without idling
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(agkf_pkg::REG_QANGLE,
                31'($urandom_range(2) == 0 ? $urandom : $urandom_range(2000)));
      write_reg(agkf_pkg::REG_QBIAS,
                31'($urandom_range(2) == 0 ? $urandom : $urandom_range(200)));
      write_reg(agkf_pkg::REG_RMEAS,
                31'($urandom_range(2) == 0 ? $urandom : $urandom_range(1, 70000)));
      write_reg(agkf_pkg::REG_DT,
                31'($urandom_range(2) == 0 ? $urandom : $urandom_range(40000)));
      no_idle = (ph == 2);
      push_random(220);
      drain();
    end
    no_idle = 1'b0;

    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
